>>> rtl/core/fcs_pkg.sv
// shared types, constants and helper functions of the fly camera step block
package fcs_pkg;

  // angle, gain and table constants (Q9.16 degrees, Q2.30 gain)
  localparam int AtanEntries = 24;
  localparam int Deg180      = 11796480;
  localparam int Deg90       = 5898240;
  localparam int PitchLim    = 5832704;
  localparam int CordicGain  = 652032874;

  // reset state of the camera
  localparam int PosXRst   = -603587;
  localparam int PosYRst   = 357171;
  localparam int PosZRst   = 970588;
  localparam int YawRst    = -3552051;
  localparam int PitchRst  = -1186202;
  localparam int SpeedRst  = 2560;
  localparam int SensRst   = 6554;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_MOVE_SPEED = 1'b0,
    REG_LOOK_SENS  = 1'b1
  } fcs_reg_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED0,
    ST_RED,
    ST_CY_GO,
    ST_CY_WAIT,
    ST_CP_GO,
    ST_CP_WAIT,
    ST_VEC,
    ST_DONE
  } fcs_state_e;

  // micro-operations of the shared multiplier, in issue order
  typedef enum logic [4:0] {
    OP_SPEED,
    OP_CR0A, OP_CR0B, OP_CR1A, OP_CR1B, OP_CR2A, OP_CR2B,
    OP_F0, OP_F1, OP_F2,
    OP_R0, OP_R1, OP_R2,
    OP_DX, OP_DY,
    OP_CYCP, OP_SYCP, OP_CYSP, OP_SYSP,
    OP_NONE
  } fcs_op_e;

  // result of one cordic run
  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } fcs_cordic_rsp_t;

  // arctangent table, Q9.16 degrees
  function automatic logic [22:0] atan_deg(input logic [4:0] idx);
    logic [22:0] r;
    case (idx)
      5'd0:  r = 23'd2949120;
      5'd1:  r = 23'd1740967;
      5'd2:  r = 23'd919879;
      5'd3:  r = 23'd466945;
      5'd4:  r = 23'd234379;
      5'd5:  r = 23'd117304;
      5'd6:  r = 23'd58666;
      5'd7:  r = 23'd29335;
      5'd8:  r = 23'd14668;
      5'd9:  r = 23'd7334;
      5'd10: r = 23'd3667;
      5'd11: r = 23'd1833;
      5'd12: r = 23'd917;
      5'd13: r = 23'd458;
      5'd14: r = 23'd229;
      5'd15: r = 23'd115;
      5'd16: r = 23'd57;
      5'd17: r = 23'd29;
      5'd18: r = 23'd14;
      5'd19: r = 23'd7;
      5'd20: r = 23'd4;
      5'd21: r = 23'd2;
      5'd22: r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

  // shift right rounding to nearest, halves away from zero
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  // saturate to +/-1.0 in Q2.14
  function automatic logic signed [15:0] sat14(input logic signed [63:0] v);
    if (v > 64'sd16384) return 16'sd16384;
    if (v < -64'sd16384) return -16'sd16384;
    return v[15:0];
  endfunction

endpackage

>>> rtl/core/fcs_cordic.sv
// iterative rotation-mode cordic giving cos and sin of a Q9.16 degree angle
module fcs_cordic import fcs_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [24:0] angle_i,
  output fcs_cordic_rsp_t    rsp_o
);

  localparam int unsigned NumSteps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
  localparam logic [4:0] LastStep = 5'(NumSteps - 1);
  localparam logic signed [25:0] D90  = 26'(Deg90);
  localparam logic signed [25:0] D180 = 26'(Deg180);

  logic               busy_q, done_q, flip_q;
  logic [4:0]         i_q;
  logic signed [33:0] x_q, y_q, x_nx, y_nx, xs, ys;
  logic signed [25:0] z_q, z_nx, z_ld, ang, atan_v;
  logic               flip_ld;
  logic signed [31:0] c_q, s_q;

  // fold the angle into [-90, 90]
  always_comb begin
    ang     = 26'(angle_i);
    flip_ld = 1'b0;
    z_ld    = ang;
    if (ang > D90) begin
      z_ld    = ang - D180;
      flip_ld = 1'b1;
    end else if (ang < -D90) begin
      z_ld    = ang + D180;
      flip_ld = 1'b1;
    end
  end

  // one micro-rotation
  always_comb begin
    xs     = x_q >>> i_q;
    ys     = y_q >>> i_q;
    atan_v = 26'(atan_deg(i_q));
    if (!z_q[25]) begin
      x_nx = x_q - ys;
      y_nx = y_q + xs;
      z_nx = z_q - atan_v;
    end else begin
      x_nx = x_q + ys;
      y_nx = y_q - xs;
      z_nx = z_q + atan_v;
    end
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= busy_q && (i_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        if (i_q == LastStep) begin
          busy_q <= 1'b0;
        end
        i_q <= i_q + 5'd1;
      end
    end
  end

  // rotation datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= 34'(CordicGain);
      y_q    <= '0;
      z_q    <= z_ld;
      flip_q <= flip_ld;
    end else if (busy_q) begin
      x_q <= x_nx;
      y_q <= y_nx;
      z_q <= z_nx;
      if (i_q == LastStep) begin
        c_q <= flip_q ? 32'(-x_nx) : 32'(x_nx);
        s_q <= flip_q ? 32'(-y_nx) : 32'(y_nx);
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = c_q;
  assign rsp_o.sin_v = s_q;

endmodule

>>> rtl/core/fly_camera_step.sv
// top level of the fly camera step: sequencer, shared multiplier and camera state
//
// One input beat on the s_axis channel is one frame: fly button, six movement
// keys, mouse deltas and frame time. Each input beat gives exactly one output
// beat on m_axis with the camera state after the frame. The cfg channel writes
// move speed (index 0) and look sensitivity (index 1); it is always ready.
// A frame in select mode goes from accept straight to the done state and the
// output register. In a frame in fly mode one 32x32 multiplier does the
// nineteen products in turn, the yaw wrap takes one lift step and eight
// compare-subtract steps and one cordic unit runs once for yaw, once for pitch.
// The block takes no new frame until the current one has reached the output
// register. After reset the block rebuilds its view vectors from the reset
// angles with s_axis_tready low and no output beat. A result waiting on a
// stalled receiver is held in the output register while the next frame is
// accepted and worked on; that frame waits at its end until the output
// register is free.
module fly_camera_step import fcs_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // fly_button, move_keys[5:0], mouse_dx[15:0], mouse_dy[15:0], frame_time[15:0]
  input  logic [55:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fly_mode, pos_x, pos_y, pos_z, front_x, front_y, front_z, up_x, up_y, up_z,
  // yaw_out[24:0], pitch_out[23:0]
  output logic [247:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  localparam logic signed [34:0] Deg180W = 35'(Deg180);
  localparam logic signed [34:0] Deg360W = 35'(2 * Deg180);
  localparam logic signed [34:0] PLimW   = 35'(PitchLim);
  localparam logic signed [33:0] I32Max  = 34'sd2147483647;
  localparam logic signed [33:0] I32Min  = -34'sd2147483648;

  fcs_state_e state_q, state_d;
  fcs_op_e    op_q, mop_q;
  logic       mv_q, boot_q;
  logic       accept, issue, cstart, out_load;
  logic signed [24:0] cangle;
  fcs_cordic_rsp_t crsp;

  logic [15:0]        ms_q, sens_q;
  logic               mode_q;
  logic signed [31:0] pos_q [3];
  logic signed [24:0] yaw_q;
  logic signed [23:0] pitch_q;

  logic [5:0]         keys_q;
  logic signed [15:0] dx_q, dy_q;
  logic [15:0]        ft_q;
  logic [23:0]        spd_q, spd_new;
  logic signed [30:0] cr_q [3];
  logic signed [29:0] dlt_q [3];
  logic signed [29:0] fd, rd, fwd_d, side_d, vert_d;
  logic signed [34:0] red_q, red_nx, modk, pt_sum, pt_clamp;
  logic [2:0]         rk_q;
  logic signed [31:0] cy_q, sy_q, cp_q, sp_q;
  logic signed [15:0] front_q [3];
  logic signed [15:0] up_q [3];

  logic signed [31:0] ma, mb;
  logic signed [63:0] p_d, p_q, rnd14, rnd28, rnd46;
  logic signed [33:0] pos_sum [3];
  logic signed [31:0] pos_sat [3];

  logic         m_tvalid_q;
  logic [247:0] m_tdata_q;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // cordic unit shared by yaw and pitch
  fcs_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cstart),
    .angle_i(cangle),
    .rsp_o  (crsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (accept) state_d = s_axis_tdata[0] ? ST_MUL : ST_DONE;
      ST_MUL:     if (mv_q && mop_q == OP_DY) state_d = ST_RED0;
      ST_RED0:    state_d = ST_RED;
      ST_RED:     if (rk_q == 3'd0) state_d = ST_CY_GO;
      ST_CY_GO:   state_d = ST_CY_WAIT;
      ST_CY_WAIT: if (crsp.done) state_d = ST_CP_GO;
      ST_CP_GO:   state_d = ST_CP_WAIT;
      ST_CP_WAIT: if (crsp.done) state_d = ST_VEC;
      ST_VEC:     if (mv_q && mop_q == OP_SYSP) state_d = ST_DONE;
      ST_DONE:    if (boot_q || out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    issue    = ((state_q == ST_MUL) && (op_q < OP_CYCP)) ||
               ((state_q == ST_VEC) && (op_q != OP_NONE));
    cstart   = (state_q == ST_CY_GO) || (state_q == ST_CP_GO);
    cangle   = (state_q == ST_CP_GO) ? 25'(pitch_q) : yaw_q;
    out_load = (state_q == ST_DONE) && !boot_q && (!m_tvalid_q || m_axis_tready);
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (op_q)
      OP_SPEED: begin ma = {16'd0, ms_q};    mb = {16'd0, ft_q};   end
      OP_CR0A:  begin ma = 32'(front_q[1]);  mb = 32'(up_q[2]);    end
      OP_CR0B:  begin ma = 32'(front_q[2]);  mb = 32'(up_q[1]);    end
      OP_CR1A:  begin ma = 32'(front_q[2]);  mb = 32'(up_q[0]);    end
      OP_CR1B:  begin ma = 32'(front_q[0]);  mb = 32'(up_q[2]);    end
      OP_CR2A:  begin ma = 32'(front_q[0]);  mb = 32'(up_q[1]);    end
      OP_CR2B:  begin ma = 32'(front_q[1]);  mb = 32'(up_q[0]);    end
      OP_F0:    begin ma = 32'(front_q[0]);  mb = {8'd0, spd_q};   end
      OP_F1:    begin ma = 32'(front_q[1]);  mb = {8'd0, spd_q};   end
      OP_F2:    begin ma = 32'(front_q[2]);  mb = {8'd0, spd_q};   end
      OP_R0:    begin ma = 32'(cr_q[0]);     mb = {8'd0, spd_q};   end
      OP_R1:    begin ma = 32'(cr_q[1]);     mb = {8'd0, spd_q};   end
      OP_R2:    begin ma = 32'(cr_q[2]);     mb = {8'd0, spd_q};   end
      OP_DX:    begin ma = 32'(dx_q);        mb = {16'd0, sens_q}; end
      OP_DY:    begin ma = 32'(dy_q);        mb = {16'd0, sens_q}; end
      OP_CYCP:  begin ma = cy_q;             mb = cp_q;            end
      OP_SYCP:  begin ma = sy_q;             mb = cp_q;            end
      OP_CYSP:  begin ma = cy_q;             mb = sp_q;            end
      OP_SYSP:  begin ma = sy_q;             mb = sp_q;            end
      default:  begin ma = '0;               mb = '0;              end
    endcase
    p_d = ma * mb;
  end

  // rounding of the registered product and the per-key deltas
  always_comb begin
    rnd14   = round_shift(p_q, 14);
    rnd28   = round_shift(p_q, 28);
    rnd46   = round_shift(p_q, 46);
    fd      = rnd14[29:0];
    rd      = rnd28[29:0];
    fwd_d   = (keys_q[0] ? fd : 30'sd0) - (keys_q[1] ? fd : 30'sd0);
    side_d  = (keys_q[3] ? rd : 30'sd0) - (keys_q[2] ? rd : 30'sd0);
    spd_new = 24'(({1'b0, p_q[31:0]} + 33'd128) >> 8);
    vert_d  = (keys_q[5] ? 30'(spd_new) : 30'sd0) - (keys_q[4] ? 30'(spd_new) : 30'sd0);
  end

  // position sum with saturation
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos_sum[k] = 34'(pos_q[k]) + 34'(dlt_q[k]);
      if (pos_sum[k] > I32Max)      pos_sat[k] = 32'sh7fffffff;
      else if (pos_sum[k] < I32Min) pos_sat[k] = 32'sh80000000;
      else                          pos_sat[k] = pos_sum[k][31:0];
    end
  end

  // pitch clamp and yaw compare-subtract step
  always_comb begin
    pt_sum = 35'(pitch_q) + $signed(p_q[34:0]);
    if (pt_sum > PLimW)       pt_clamp = PLimW;
    else if (pt_sum < -PLimW) pt_clamp = -PLimW;
    else                      pt_clamp = pt_sum;
    modk   = Deg360W <<< rk_q;
    red_nx = (red_q >= modk) ? red_q - modk : red_q;
  end

  // control and camera state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CY_GO;
      op_q       <= OP_CYCP;
      mv_q       <= 1'b0;
      boot_q     <= 1'b1;
      ms_q       <= 16'(SpeedRst);
      sens_q     <= 16'(SensRst);
      mode_q     <= 1'b0;
      pos_q[0]   <= 32'(PosXRst);
      pos_q[1]   <= 32'(PosYRst);
      pos_q[2]   <= 32'(PosZRst);
      yaw_q      <= 25'(YawRst);
      pitch_q    <= 24'(PitchRst);
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mv_q    <= issue;
      if (issue) begin
        op_q <= fcs_op_e'(op_q + 5'd1);
      end
      if (accept) begin
        mode_q <= s_axis_tdata[0];
        if (s_axis_tdata[0]) begin
          op_q <= OP_SPEED;
        end
      end
      if ((state_q == ST_DONE) && boot_q) begin
        boot_q <= 1'b0;
      end
      // configuration writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MOVE_SPEED: ms_q   <= cfg_data_i;
          REG_LOOK_SENS:  sens_q <= cfg_data_i;
          default:        ;
        endcase
      end
      // all deltas are in once the pitch product lands
      if (mv_q && mop_q == OP_DY) begin
        pitch_q <= pt_clamp[23:0];
        for (int k = 0; k < 3; k++) begin
          pos_q[k] <= pos_sat[k];
        end
      end
      if ((state_q == ST_RED) && (rk_q == 3'd0)) begin
        yaw_q <= 25'(red_nx - Deg180W);
      end
      // output register
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    mop_q <= op_q;
    if (accept) begin
      keys_q <= s_axis_tdata[6:1];
      dx_q   <= s_axis_tdata[22:7];
      dy_q   <= s_axis_tdata[38:23];
      ft_q   <= s_axis_tdata[54:39];
    end
    if (mv_q) begin
      case (mop_q)
        OP_SPEED: begin
          spd_q    <= spd_new;
          dlt_q[0] <= '0;
          dlt_q[1] <= vert_d;
          dlt_q[2] <= '0;
        end
        OP_CR0A: cr_q[0] <= p_q[30:0];
        OP_CR0B: cr_q[0] <= cr_q[0] - p_q[30:0];
        OP_CR1A: cr_q[1] <= p_q[30:0];
        OP_CR1B: cr_q[1] <= cr_q[1] - p_q[30:0];
        OP_CR2A: cr_q[2] <= p_q[30:0];
        OP_CR2B: cr_q[2] <= cr_q[2] - p_q[30:0];
        OP_F0:   dlt_q[0] <= dlt_q[0] + fwd_d;
        OP_F1:   dlt_q[1] <= dlt_q[1] + fwd_d;
        OP_F2:   dlt_q[2] <= dlt_q[2] + fwd_d;
        OP_R0:   dlt_q[0] <= dlt_q[0] + side_d;
        OP_R1:   dlt_q[1] <= dlt_q[1] + side_d;
        OP_R2:   dlt_q[2] <= dlt_q[2] + side_d;
        OP_DX:   red_q <= 35'(yaw_q) + $signed(p_q[34:0]) + Deg180W;
        OP_CYCP: front_q[0] <= sat14(rnd46);
        OP_SYCP: front_q[2] <= sat14(rnd46);
        OP_CYSP: up_q[0] <= sat14(-rnd46);
        OP_SYSP: up_q[2] <= sat14(-rnd46);
        default: ;
      endcase
    end
    // yaw wrap: lift negatives, then subtract 360 deg multiples high to low
    if (state_q == ST_RED0) begin
      if (red_q < 0) begin
        red_q <= red_q + (Deg360W <<< 7);
      end
      rk_q <= 3'd7;
    end else if (state_q == ST_RED) begin
      red_q <= red_nx;
      rk_q  <= rk_q - 3'd1;
    end
    // cordic results
    if ((state_q == ST_CY_WAIT) && crsp.done) begin
      cy_q <= crsp.cos_v;
      sy_q <= crsp.sin_v;
    end
    if ((state_q == ST_CP_WAIT) && crsp.done) begin
      cp_q       <= crsp.cos_v;
      sp_q       <= crsp.sin_v;
      front_q[1] <= sat14(round_shift(64'(crsp.sin_v), 16));
      up_q[1]    <= sat14(round_shift(64'(crsp.cos_v), 16));
    end
    if (out_load) begin
      m_tdata_q <= {6'd0, pitch_q, yaw_q,
                    up_q[2], up_q[1], up_q[0],
                    front_q[2], front_q[1], front_q[0],
                    pos_q[2], pos_q[1], pos_q[0], mode_q};
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

>>> rtl/core/fcs_checker.sv
// port-level checks of the fly camera step, bound to the top level
module fcs_checker import fcs_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [247:0] m_axis_tdata
);

  localparam logic signed [23:0] PLim = 24'(PitchLim);
  localparam logic signed [24:0] YLim = 25'(Deg180);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // one frame at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // pitch stays clamped
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[241:218]) <= PLim) &&
                      ($signed(m_axis_tdata[241:218]) >= -PLim))
    else $error("pitch outside clamp");

  // yaw stays wrapped
  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[217:193]) < YLim) &&
                      ($signed(m_axis_tdata[217:193]) >= -YLim))
    else $error("yaw outside wrap range");

endmodule

bind fly_camera_step fcs_checker u_fcs_checker (.*);
